### hdl/fspa_pkg.sv
package fspa_pkg;

   localparam int CMD_W       = 2;
   localparam int CFG_IDX_W   = 2;
   localparam int CFG_DATA_W  = 32;
   localparam int BYTES_W     = 26;
   localparam int COUNT_W     = 11;
   localparam int ADDR_OUT_W  = 32;
   localparam int INDEX_OUT_W = 10;
   localparam int POOL_W      = 27;
   localparam int OBJ_W       = 16;
   localparam int ALIGN_W     = 8;
   localparam int DIV_STEPS   = POOL_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 80;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES   = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT    = 2'd3;

   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_ALIGN = 6'b000100,
      S_DIV   = 6'b001000,
      S_FILL  = 6'b010000,
      S_WAIT  = 6'b100000
   } state_type;

endpackage

### hdl/fspa_ram.sv
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fixed_slot_pool_allocator.sv
// Fixed-size slot pool with a linked free list kept in one link memory of SLOTS entries.
// Commands arrive on req_ (command in tuser, slot in tdata), one result per command leaves
// on rsp_. Allocate, free and the unused code are handled in S_EXEC: the accept cycle issues the
// link-memory read and the slot-times-size product, the next cycle updates the head and
// counters. Clear runs an alignment step (S_ALIGN), a bit-serial divider for the slot count
// (S_DIV), then one link-memory write per slot (S_FILL). One command is in flight at a time;
// a finished result may wait in the output register while the next command is accepted.
// Configuration writes on csr_ are taken in any cycle.
module fixed_slot_pool_allocator
   import fspa_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // free_slot[9:0], zero pad
   input  logic [CMD_W-1:0]      req_tuser,  // command[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot_index[9:0], slot_address[41:10], used_bytes[67:42], allocation_count[78:68], pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser,  // status[0]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int PROD_W = ADDR_W + OBJ_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

   state_type state_ff, state_in;

   logic [ADDR_OUT_W-1:0] base_ff;
   logic [POOL_W-1:0]     pool_ff;
   logic [OBJ_W-1:0]      obj_ff;
   logic [ALIGN_W-1:0]    align_ff;

   logic [LINK_W-1:0]     head_ff, head_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ADDR_OUT_W-1:0] abase_ff, abase_in;

   logic [CMD_W-1:0]       cmd_ff;
   logic [INDEX_OUT_W-1:0] slot_ff;
   logic [PROD_W-1:0]      prod_ff;

   logic [POOL_W-1:0] divq_ff, divq_in;
   logic [OBJ_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LINK_W-1:0] fill_ff, fill_in;

   logic                   res_status_ff, res_status_in;
   logic [INDEX_OUT_W-1:0] res_idx_ff, res_idx_in;
   logic [ADDR_OUT_W-1:0]  res_addr_ff, res_addr_in;

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [LINK_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [LINK_W-1:0] mem_rd_data;

   logic              accept;
   logic              out_free;
   logic              out_load;
   logic              out_status;
   logic [INDEX_OUT_W-1:0] out_idx;
   logic [ADDR_OUT_W-1:0]  out_addr;
   logic [BYTES_W-1:0]     out_bytes;
   logic [COUNT_W-1:0]     out_count;

   logic [ALIGN_W-1:0] align_mask;
   logic [ALIGN_W-1:0] adj;
   logic [OBJ_W:0]     div_shift;
   logic               div_ge;
   logic [LINK_W-1:0]  slot_count;
   logic [POOL_W:0]    bytes_sum;
   logic               head_empty;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign head_empty = (head_ff >= NULL_LINK);

   assign align_mask = align_ff - ALIGN_W'(1);
   assign adj = (align_ff == '0) ? '0 : ((align_ff - (base_ff[ALIGN_W-1:0] & align_mask))
                                         & align_mask);

   assign div_shift = {rem_ff, divq_ff[POOL_W-1]};
   assign div_ge    = (div_shift >= {1'b0, obj_ff});

   assign slot_count = (divq_ff > POOL_W'(SLOTS)) ? NULL_LINK : divq_ff[LINK_W-1:0];

   assign bytes_sum = {1'b0, bytes_ff} + (POOL_W + 1)'(obj_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pool_ff  <= '0;
         obj_ff   <= OBJ_W'(1);
         align_ff <= ALIGN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BASE_ADDRESS: base_ff  <= csr_data;
            REG_POOL_BYTES:   pool_ff  <= csr_data[POOL_W-1:0];
            REG_OBJECT_SIZE:  obj_ff   <= csr_data[OBJ_W-1:0];
            REG_ALIGNMENT:    align_ff <= csr_data[ALIGN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      bytes_in      = bytes_ff;
      count_in      = count_ff;
      abase_in      = abase_ff;
      divq_in       = divq_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      fill_in       = fill_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_addr_in   = res_addr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ADDR_W'(slot_ff);
      mem_wr_data   = head_ff;
      mem_rd_en     = 1'b0;
      out_load      = 1'b0;
      out_status    = res_status_ff;
      out_idx       = res_idx_ff;
      out_addr      = res_addr_ff;
      out_bytes     = bytes_ff;
      out_count     = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_rd_en = 1'b1;
               state_in  = (req_tuser == CMD_CLEAR) ? S_ALIGN : S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = 1'b0;
            res_idx_in    = '0;
            res_addr_in   = '0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (head_empty) begin
                     res_status_in = 1'b1;
                  end else begin
                     res_idx_in  = INDEX_OUT_W'(head_ff);
                     res_addr_in = abase_ff + ADDR_OUT_W'(prod_ff);
                     head_in     = (mem_rd_data > NULL_LINK) ? NULL_LINK : mem_rd_data;
                     bytes_in    = bytes_sum[POOL_W:BYTES_W] != '0 ? BYTES_MAX
                                                                  : bytes_sum[BYTES_W-1:0];
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
               end
               CMD_FREE: begin
                  if (32'(slot_ff) < SLOTS) begin
                     mem_wr_en = 1'b1;
                     head_in   = LINK_W'(ADDR_W'(slot_ff));
                     bytes_in  = (bytes_ff > BYTES_W'(obj_ff)) ? bytes_ff - BYTES_W'(obj_ff)
                                                               : '0;
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
            out_status = res_status_in;
            out_idx    = res_idx_in;
            out_addr   = res_addr_in;
            out_bytes  = bytes_in;
            out_count  = count_in;
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_ALIGN: begin
            res_status_in = 1'b0;
            res_idx_in    = '0;
            res_addr_in   = '0;
            abase_in      = base_ff + ADDR_OUT_W'(adj);
            rem_in        = '0;
            step_in       = '0;
            fill_in       = '0;
            divq_in       = pool_ff - POOL_W'(adj);
            if (obj_ff == '0 || pool_ff < POOL_W'(adj)) begin
               head_in  = NULL_LINK;
               state_in = S_WAIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = div_ge ? OBJ_W'(div_shift - {1'b0, obj_ff}) : div_shift[OBJ_W-1:0];
            divq_in = {divq_ff[POOL_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (slot_count == '0) begin
               head_in  = NULL_LINK;
               state_in = S_WAIT;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = fill_ff[ADDR_W-1:0];
               mem_wr_data = (fill_ff + LINK_W'(1) == slot_count) ? NULL_LINK
                                                                  : fill_ff + LINK_W'(1);
               fill_in     = fill_ff + LINK_W'(1);
               if (fill_ff + LINK_W'(1) == slot_count) begin
                  head_in  = '0;
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         bytes_ff     <= '0;
         count_ff     <= '0;
         abase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         abase_ff <= abase_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         slot_ff <= req_tdata[INDEX_OUT_W-1:0];
         prod_ff <= head_ff[ADDR_W-1:0] * obj_ff;
      end
      divq_ff       <= divq_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      fill_ff       <= fill_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_addr_ff   <= res_addr_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_data_ff   <= {1'b0, out_count, out_bytes, out_addr, out_idx};
      end
   end

   fspa_ram #(
      .WIDTH(LINK_W),
      .DEPTH(SLOTS)
   ) link_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(head_ff[ADDR_W-1:0]),
      .rd_data(mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### sim/fixed_slot_pool_allocator_test.sv
`timescale 1ns / 1ps

module fixed_slot_pool_allocator_test;
   import fspa_pkg::*;

   localparam int POOL_SLOTS = 1024;
   localparam logic [10:0] NULL_LINK = 11'(POOL_SLOTS);
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [26:0] POOL_MAX = 27'h7FF_FFFF;

   typedef struct packed {
      logic        status;
      logic [9:0]  slot_index;
      logic [31:0] slot_address;
      logic [25:0] used_bytes;
      logic [10:0] allocation_count;
   } pool_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // free_slot[9:0], zero pad
   logic [CMD_W-1:0]      req_tuser = '0;  // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // slot_index[9:0], slot_address[41:10], used_bytes[67:42], allocation_count[78:68], pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;  // status[0]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [31:0]   cfg_base = '0;
   logic [26:0]   cfg_pool = '0;
   logic [15:0]   cfg_obj = 16'd1;
   logic [7:0]    cfg_align = 8'd1;
   logic [10:0]   link_mem [POOL_SLOTS];
   logic [10:0]   free_head = NULL_LINK;
   logic [25:0]   bytes_used = '0;
   logic [10:0]   live_count = '0;
   logic [31:0]   aligned_base = '0;

   pool_reply_type expected_replies [$];
   int            live_slots [$];
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   int            failures = 0;
   int            cycle_count = 0;
   int            n_alloc = 0;
   int            n_empty = 0;
   int            n_free = 0;
   int            n_clear = 0;
   int            n_transfers = 0;

   fixed_slot_pool_allocator #(
      .SLOTS(POOL_SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic void rebuild_free_list();
      logic [31:0] mask;
      logic [31:0] adj;
      logic [31:0] slots;
      adj = '0;
      if (cfg_align != 8'd0) begin
         mask = 32'(cfg_align) - 32'd1;
         adj = (32'(cfg_align) - (cfg_base & mask)) & mask;
      end
      aligned_base = cfg_base + adj;
      slots = '0;
      if (cfg_obj != 16'd0 && 32'(cfg_pool) >= adj) begin
         slots = (32'(cfg_pool) - adj) / 32'(cfg_obj);
      end
      if (slots > 32'(POOL_SLOTS)) begin
         slots = 32'(POOL_SLOTS);
      end
      if (slots == 32'd0) begin
         free_head = NULL_LINK;
      end else begin
         for (int i = 0; i + 1 < int'(slots); i++) begin
            link_mem[i] = 11'(i + 1);
         end
         link_mem[slots - 1] = NULL_LINK;
         free_head = '0;
      end
   endfunction

   function automatic pool_reply_type pool_step(input logic [CMD_W-1:0] cmd,
                                                input logic [9:0] slot);
      pool_reply_type reply;
      logic [10:0] nx;
      logic [31:0] sum;
      reply = '0;
      case (cmd)
         CMD_ALLOC: begin
            if (free_head >= NULL_LINK) begin
               reply.status = 1'b1;
            end else begin
               reply.slot_index = free_head[9:0];
               nx = link_mem[free_head[9:0]];
               free_head = (nx > NULL_LINK) ? NULL_LINK : nx;
               reply.slot_address = aligned_base + 32'(reply.slot_index) * 32'(cfg_obj);
               sum = 32'(bytes_used) + 32'(cfg_obj);
               bytes_used = (sum > 32'(BYTES_MAX)) ? BYTES_MAX : sum[25:0];
               if (live_count < COUNT_MAX) begin
                  live_count = live_count + 11'd1;
               end
            end
         end
         CMD_FREE: begin
            link_mem[slot] = free_head;
            free_head = {1'b0, slot};
            bytes_used = (32'(bytes_used) > 32'(cfg_obj)) ? bytes_used - 26'(cfg_obj) : '0;
            if (live_count > 11'd0) begin
               live_count = live_count - 11'd1;
            end
         end
         CMD_CLEAR: begin
            rebuild_free_list();
         end
         default: begin
         end
      endcase
      reply.used_bytes = bytes_used;
      reply.allocation_count = live_count;
      return reply;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      pool_reply_type want;
      pool_reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[9:0], rsp_tdata[41:10], rsp_tdata[67:42],
                rsp_tdata[78:68]};
         if (expected_replies.size() == 0) begin
            $error("result transfer with nothing outstanding");
            failures++;
         end else begin
            want = expected_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            compare_field("slot_address", want.slot_address, got.slot_address);
            compare_field("used_bytes", 32'(want.used_bytes), 32'(got.used_bytes));
            compare_field("allocation_count", 32'(want.allocation_count),
                          32'(got.allocation_count));
         end
      end
   end

   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [9:0] slot);
      pool_reply_type reply;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_DATA_W'(slot);
      do @(posedge clock); while (!req_tready);
      reply = pool_step(cmd, slot);
      expected_replies.push_back(reply);
      n_transfers++;
      case (cmd)
         CMD_ALLOC: begin
            n_alloc++;
            if (reply.status) begin
               n_empty++;
            end else begin
               live_slots.push_back(int'(reply.slot_index));
            end
         end
         CMD_FREE: begin
            n_free++;
            for (int i = 0; i < live_slots.size(); i++) begin
               if (live_slots[i] == int'(slot)) begin
                  live_slots.delete(i);
                  break;
               end
            end
         end
         CMD_CLEAR: begin
            n_clear++;
            live_slots.delete();
         end
         default: begin
         end
      endcase
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   task automatic program_pool(input logic [31:0] base, input logic [26:0] pool,
                               input logic [15:0] obj, input logic [7:0] align);
      logic [CFG_IDX_W-1:0] regs [4];
      logic [31:0]          vals [4];
      regs = '{REG_BASE_ADDRESS, REG_POOL_BYTES, REG_OBJECT_SIZE, REG_ALIGNMENT};
      vals = '{base, 32'(pool), 32'(obj), 32'(align)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            REG_BASE_ADDRESS: cfg_base = vals[i];
            REG_POOL_BYTES:   cfg_pool = vals[i][26:0];
            REG_OBJECT_SIZE:  cfg_obj = vals[i][15:0];
            REG_ALIGNMENT:    cfg_align = vals[i][7:0];
            default: begin
            end
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_after_reset();
      issue_command(CMD_ALLOC, 10'h000);
      issue_command(CMD_NOP, 10'h3FF);
      issue_command(CMD_FREE, 10'h155);
      issue_command(CMD_ALLOC, 10'h2AA);
      issue_command(CMD_CLEAR, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
   endtask

   task automatic test_field_extremes();
      // aligned base wraps past the top of the address space to zero
      program_pool(32'hFFFF_FFF3, POOL_MAX, 16'hFFFF, 8'd128);
      issue_command(CMD_CLEAR, 10'h3FF);
      issue_command(CMD_ALLOC, 10'h000);
      issue_command(CMD_ALLOC, 10'h3FF);
      issue_command(CMD_FREE, 10'h3FF);
      issue_command(CMD_ALLOC, 10'h000);
      issue_command(CMD_FREE, 10'h000);
      issue_command(CMD_FREE, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      issue_command(CMD_FREE, 10'h2AA);
      issue_command(CMD_FREE, 10'h000);
      issue_command(CMD_FREE, 10'h3FF);
      wait_idle();
   endtask

   task automatic test_degenerate_configs();
      program_pool(32'h0000_1235, 27'd1000, 16'd10, 8'd0);
      issue_command(CMD_CLEAR, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
      program_pool(32'h0000_1001, 27'd400, 16'd7, 8'd3);
      issue_command(CMD_CLEAR, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
      program_pool(32'h0000_0041, 27'd5, 16'd4, 8'd64);
      issue_command(CMD_CLEAR, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
      program_pool(32'h8000_0000, 27'd1000, 16'd0, 8'd1);
      issue_command(CMD_CLEAR, 10'h000);
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
   endtask

   task automatic test_counter_saturation();
      program_pool($urandom, POOL_MAX, 16'hFFFF, 8'd1);
      issue_command(CMD_CLEAR, 10'h000);
      for (int i = 0; i < POOL_SLOTS; i++) begin
         issue_command(CMD_ALLOC, 10'($urandom));
      end
      issue_command(CMD_ALLOC, 10'h000);
      // rebuild with the counters kept, so the byte total runs into its ceiling
      issue_command(CMD_CLEAR, 10'h001);
      for (int i = 0; i < 4; i++) begin
         issue_command(CMD_ALLOC, 10'($urandom));
      end
      for (int i = 0; i < 4; i++) begin
         issue_command(CMD_FREE, 10'(live_slots[$urandom_range(live_slots.size() - 1)]));
      end
      issue_command(CMD_ALLOC, 10'h000);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic [31:0] base;
      logic [26:0] pool;
      logic [15:0] obj;
      logic [7:0]  align;
      longint      span_bytes;
      int          sent;
      int          pick;
      int          target;
      int          span;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 56;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 56;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         wait_idle();
         base = $urandom;
         pick = $urandom_range(9);
         align = (pick == 9) ? 8'($urandom) : 8'(1 << pick);
         pick = $urandom_range(19);
         if (pick < 13) begin
            obj = 16'($urandom_range(1, 300));
         end else if (pick < 18) begin
            obj = 16'($urandom);
         end else if (pick == 18) begin
            obj = 16'hFFFF;
         end else begin
            obj = 16'd0;
         end
         target = ($urandom_range(7) == 0) ? POOL_SLOTS : $urandom_range(48);
         span_bytes = longint'(target) * longint'(obj) + longint'($urandom_range(300));
         pool = (span_bytes > longint'(POOL_MAX)) ? POOL_MAX : 27'(span_bytes);
         if ($urandom_range(9) == 0) begin
            pool = 27'($urandom_range(300));
         end
         program_pool(base, pool, obj, align);
         // keep the old list now and then, so allocations see the new object size
         if ($urandom_range(9) != 0) begin
            issue_command(CMD_CLEAR, 10'($urandom));
            sent++;
         end
         span = $urandom_range(30, 70);
         for (int k = 0; k < span; k++) begin
            pick = $urandom_range(99);
            if (pick < 48 || (pick < 84 && live_slots.size() == 0)) begin
               issue_command(CMD_ALLOC, 10'($urandom));
            end else if (pick < 84) begin
               issue_command(CMD_FREE,
                             10'(live_slots[$urandom_range(live_slots.size() - 1)]));
            end else if (pick < 92) begin
               issue_command(CMD_FREE, 10'($urandom));
            end else if (pick < 97) begin
               issue_command(CMD_NOP, 10'($urandom));
            end else begin
               issue_command(CMD_CLEAR, 10'($urandom));
            end
            sent++;
         end
      end
      wait_idle();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         link_mem[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_pct = 10;
      rx_idle_pct = 56;
      test_empty_after_reset();
      test_field_extremes();
      test_degenerate_configs();
      test_random_traffic();
      test_counter_saturation();
      wait_idle();
      repeat (64) @(posedge clock);
      $display("Covered %0d commands: %0d allocations (%0d on an empty pool), %0d frees,",
               n_transfers, n_alloc, n_empty, n_free);
      $display("%0d clears, under sender and receiver stalls, in %0d cycles", n_clear,
               cycle_count);
      if (failures == 0 && expected_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
